// ===== sv/voxel_face_cull_mesher_assert.svh =====
// Assertion macros shared by the mesher modules.
`ifndef VOXEL_FACE_CULL_MESHER_ASSERT_SVH
`define VOXEL_FACE_CULL_MESHER_ASSERT_SVH

// Antecedent implies consequent in the same cycle.
`define VFCM_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Antecedent implies consequent in the following cycle.
`define VFCM_ASSERT_NXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== sv/vfcm_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none

package vfcm_pkg;

    localparam int EDGE_DEF = 32;

    localparam int KIND_W  = 2;
    localparam int COORD_W = 5;
    localparam int VERT_W  = 6;
    localparam int FACE_W  = 3;
    localparam int NORM_W  = 30;
    localparam int COUNT_W = 18;
    localparam int NFACE   = 6;

    localparam int QDEPTH = 4;
    localparam int QAW    = $clog2(QDEPTH);

    localparam logic [KIND_W-1:0] KIND_WRITE = 2'd0;
    localparam logic [KIND_W-1:0] KIND_MESH  = 2'd1;
    localparam logic [KIND_W-1:0] KIND_CLEAR = 2'd2;

    localparam logic [FACE_W-1:0] FACE_NX = 3'd0;
    localparam logic [FACE_W-1:0] FACE_PX = 3'd1;
    localparam logic [FACE_W-1:0] FACE_NY = 3'd2;
    localparam logic [FACE_W-1:0] FACE_PY = 3'd3;
    localparam logic [FACE_W-1:0] FACE_NZ = 3'd4;
    localparam logic [FACE_W-1:0] FACE_PZ = 3'd5;

    // corner offsets as {x, y, z}, four per face in emission order
    localparam logic [2:0] CORNER_TAB [NFACE][4] = '{
        '{3'b000, 3'b010, 3'b011, 3'b001},
        '{3'b101, 3'b111, 3'b110, 3'b100},
        '{3'b000, 3'b001, 3'b101, 3'b100},
        '{3'b010, 3'b110, 3'b111, 3'b011},
        '{3'b100, 3'b110, 3'b010, 3'b000},
        '{3'b001, 3'b011, 3'b111, 3'b101}
    };

    typedef struct packed {
        logic               clr;
        logic [COORD_W-1:0] x;
        logic [COORD_W-1:0] y;
        logic [COORD_W-1:0] z;
        logic [NFACE-1:0]   mask;
    } t_job;

    typedef struct packed {
        logic full;
        logic empty;
    } t_q_stat;

    function automatic logic [NORM_W-1:0] face_normal(input logic [FACE_W-1:0] f);
        logic [NORM_W-1:0] n;
        unique case (f)
            FACE_NX: n = 30'h0000_0200;
            FACE_PX: n = 30'h0000_01ff;
            FACE_NY: n = 30'h0008_0000;
            FACE_PY: n = 30'h0007_fc00;
            FACE_NZ: n = 30'h2000_0000;
            FACE_PZ: n = 30'h1ff0_0000;
            default: n = '0;
        endcase
        return n;
    endfunction

    function automatic logic [2:0] corner_off(input logic [FACE_W-1:0] f,
                                              input logic [1:0] v);
        logic [2:0] o;
        o = '0;
        if (f <= FACE_PZ) begin
            o = CORNER_TAB[f][v];
        end
        return o;
    endfunction

    // lowest pending face, which keeps the -x .. +z order
    function automatic logic [FACE_W-1:0] first_face(input logic [NFACE-1:0] m);
        logic [FACE_W-1:0] f;
        f = FACE_NX;
        for (int i = NFACE - 1; i >= 0; i--) begin
            if (m[i]) begin
                f = FACE_W'(i);
            end
        end
        return f;
    endfunction

endpackage

`default_nettype wire

// ===== sv/vfcm_if.sv =====
`timescale 1ns / 1ps
`default_nettype none

interface vfcm_in_if import vfcm_pkg::*; ();
    logic               valid;
    logic               ready;
    logic [KIND_W-1:0]  kind;
    logic [COORD_W-1:0] vox_x;
    logic [COORD_W-1:0] vox_y;
    logic [COORD_W-1:0] vox_z;
    logic               filled;

    modport source (output valid, kind, vox_x, vox_y, vox_z, filled, input ready);
    modport sink   (input valid, kind, vox_x, vox_y, vox_z, filled, output ready);
endinterface

interface vfcm_out_if import vfcm_pkg::*; ();
    logic               valid;
    logic               ready;
    logic [VERT_W-1:0]  vert_x;
    logic [VERT_W-1:0]  vert_y;
    logic [VERT_W-1:0]  vert_z;
    logic [FACE_W-1:0]  face_dir;
    logic [NORM_W-1:0]  normal_word;
    logic [COUNT_W-1:0] faces_so_far;
    logic               last;

    modport source (output valid, vert_x, vert_y, vert_z, face_dir, normal_word,
                     faces_so_far, last, input ready);
    modport sink   (input valid, vert_x, vert_y, vert_z, face_dir, normal_word,
                     faces_so_far, last, output ready);
endinterface

`default_nettype wire

// ===== sv/vfcm_ram.sv =====
`timescale 1ns / 1ps
`default_nettype none

module vfcm_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

`default_nettype wire

// ===== sv/vfcm_front.sv =====
`timescale 1ns / 1ps
`default_nettype none

module vfcm_front import vfcm_pkg::*; #(
    parameter int EDGE = EDGE_DEF
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    vfcm_in_if.sink                       i_vox,
    input  t_q_stat                       i_q_stat,
    output logic                          o_push,
    output t_job                          o_job,
    output logic                          o_we,
    output logic [2*$clog2(EDGE)-1:0]     o_waddr,
    output logic [EDGE-1:0]               o_wdata,
    output logic [2*$clog2(EDGE)-1:0]     o_raddr,
    input  logic [EDGE-1:0]               i_rdata
);

    localparam int CW  = $clog2(EDGE);
    localparam int RAW = 2 * CW;
    localparam logic [COORD_W+1:0] EDGE_V = (COORD_W + 2)'(EDGE);

    localparam logic [2:0] S_INIT = 3'd0;
    localparam logic [2:0] S_IDLE = 3'd1;
    localparam logic [2:0] S_WRD  = 3'd2;
    localparam logic [2:0] S_WWB  = 3'd3;
    localparam logic [2:0] S_MESH = 3'd4;
    localparam logic [2:0] S_PUSH = 3'd5;

    logic [2:0]         r_state;
    logic [RAW-1:0]     r_clr_addr;
    logic [COORD_W-1:0] r_x;
    logic [COORD_W-1:0] r_y;
    logic [COORD_W-1:0] r_z;
    logic               r_fill;
    logic [2:0]         r_step;
    logic               r_solid;
    logic [NFACE-1:0]   r_mask;

    logic           w_acc;
    logic           w_inr;
    logic [CW-1:0]  w_cx;
    logic [CW-1:0]  w_cy;
    logic [CW-1:0]  w_cz;
    logic           w_x_lo;
    logic           w_x_hi;
    logic           w_y_lo;
    logic           w_y_hi;
    logic           w_z_lo;
    logic           w_z_hi;
    logic           w_bz;
    logic           w_bzm;
    logic           w_bzp;
    logic           w_emit;
    logic [EDGE-1:0] w_row_mod;

    assign w_acc = i_vox.valid && i_vox.ready;
    assign w_inr = ({2'b00, i_vox.vox_x} < EDGE_V) && ({2'b00, i_vox.vox_y} < EDGE_V)
                && ({2'b00, i_vox.vox_z} < EDGE_V);

    assign w_cx = CW'(r_x);
    assign w_cy = CW'(r_y);
    assign w_cz = CW'(r_z);

    // neighbour inside the chunk on each side
    assign w_x_lo = (r_x != '0);
    assign w_y_lo = (r_y != '0);
    assign w_z_lo = (r_z != '0);
    assign w_x_hi = (({2'b00, r_x} + (COORD_W + 2)'(1)) < EDGE_V);
    assign w_y_hi = (({2'b00, r_y} + (COORD_W + 2)'(1)) < EDGE_V);
    assign w_z_hi = (({2'b00, r_z} + (COORD_W + 2)'(1)) < EDGE_V);

    assign w_bz  = i_rdata[w_cz];
    assign w_bzm = i_rdata[w_cz - CW'(1)];
    assign w_bzp = i_rdata[w_cz + CW'(1)];

    always_comb begin
        w_row_mod       = i_rdata;
        w_row_mod[w_cz] = r_fill;
    end

    // rows: centre, x-1, x+1, y-1, y+1
    always_comb begin
        unique case (r_step)
            3'd1:    o_raddr = {w_cx - CW'(1), w_cy};
            3'd2:    o_raddr = {w_cx + CW'(1), w_cy};
            3'd3:    o_raddr = {w_cx, w_cy - CW'(1)};
            3'd4:    o_raddr = {w_cx, w_cy + CW'(1)};
            default: o_raddr = {w_cx, w_cy};
        endcase
    end

    assign o_we    = (r_state == S_INIT) || (r_state == S_WWB);
    assign o_waddr = (r_state == S_INIT) ? r_clr_addr : {w_cx, w_cy};
    assign o_wdata = (r_state == S_INIT) ? '0 : w_row_mod;

    assign i_vox.ready = (r_state == S_IDLE) && !i_q_stat.full;

    assign w_emit = r_solid && (r_mask != '0);
    assign o_push = ((r_state == S_PUSH) && w_emit && !i_q_stat.full)
                 || (w_acc && (i_vox.kind == KIND_CLEAR));
    assign o_job.clr  = (r_state == S_IDLE);
    assign o_job.x    = r_x;
    assign o_job.y    = r_y;
    assign o_job.z    = r_z;
    assign o_job.mask = r_mask;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= S_INIT;
            r_clr_addr <= '0;
            r_step     <= '0;
        end else begin
            unique case (r_state)
                S_INIT: begin
                    r_clr_addr <= r_clr_addr + RAW'(1);
                    if (&r_clr_addr) begin
                        r_state <= S_IDLE;
                    end
                end
                S_IDLE: begin
                    r_step <= '0;
                    if (w_acc && w_inr) begin
                        priority if (i_vox.kind == KIND_MESH) begin
                            r_state <= S_MESH;
                        end else if (i_vox.kind == KIND_WRITE) begin
                            r_state <= S_WRD;
                        end else begin
                            r_state <= S_IDLE;
                        end
                    end
                end
                S_WRD: r_state <= S_WWB;
                S_WWB: r_state <= S_IDLE;
                S_MESH: begin
                    r_step <= r_step + 3'd1;
                    if (r_step == 3'd5) begin
                        r_state <= S_PUSH;
                    end
                end
                S_PUSH: begin
                    if (!w_emit || !i_q_stat.full) begin
                        r_state <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    // payload: latch the item, then gather neighbour bits one row a cycle
    always_ff @(posedge i_clk) begin
        if (w_acc) begin
            r_x    <= i_vox.vox_x;
            r_y    <= i_vox.vox_y;
            r_z    <= i_vox.vox_z;
            r_fill <= i_vox.filled;
        end
        if (r_state == S_MESH) begin
            unique case (r_step)
                3'd1: begin
                    r_solid   <= w_bz;
                    r_mask[4] <= !w_z_lo || !w_bzm;
                    r_mask[5] <= !w_z_hi || !w_bzp;
                end
                3'd2:    r_mask[0] <= !w_x_lo || !w_bz;
                3'd3:    r_mask[1] <= !w_x_hi || !w_bz;
                3'd4:    r_mask[2] <= !w_y_lo || !w_bz;
                3'd5:    r_mask[3] <= !w_y_hi || !w_bz;
                default: r_solid   <= r_solid;
            endcase
        end
    end

endmodule

`default_nettype wire

// ===== sv/vfcm_queue.sv =====
`timescale 1ns / 1ps
`default_nettype none
`include "voxel_face_cull_mesher_assert.svh"

module vfcm_queue import vfcm_pkg::*; (
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_push,
    input  t_job    i_job,
    input  logic    i_pop,
    output t_job    o_head,
    output t_q_stat o_stat
);

    t_job            r_mem [QDEPTH];
    logic [QAW-1:0]  r_wp;
    logic [QAW-1:0]  r_rp;
    logic [QAW:0]    r_cnt;

    assign o_stat.full  = (r_cnt == (QAW + 1)'(QDEPTH));
    assign o_stat.empty = (r_cnt == '0);
    assign o_head       = r_mem[r_rp];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (i_push) begin
                r_wp <= r_wp + QAW'(1);
            end
            if (i_pop) begin
                r_rp <= r_rp + QAW'(1);
            end
            unique case ({i_push, i_pop})
                2'b10:   r_cnt <= r_cnt + (QAW + 1)'(1);
                2'b01:   r_cnt <= r_cnt - (QAW + 1)'(1);
                default: r_cnt <= r_cnt;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wp] <= i_job;
        end
    end

    `VFCM_ASSERT_IMP(a_push_not_full, i_clk, i_rst_n, i_push, !o_stat.full, "push into full queue")
    `VFCM_ASSERT_IMP(a_pop_not_empty, i_clk, i_rst_n, i_pop, !o_stat.empty, "pop from empty queue")

endmodule

`default_nettype wire

// ===== sv/vfcm_back.sv =====
`timescale 1ns / 1ps
`default_nettype none
`include "voxel_face_cull_mesher_assert.svh"

module vfcm_back import vfcm_pkg::*; (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  t_job       i_head,
    input  t_q_stat    i_q_stat,
    output logic       o_pop,
    vfcm_out_if.source o_vert
);

    logic               r_busy;
    logic               r_ov;
    logic [1:0]         r_vert;
    logic [COUNT_W-1:0] r_count;
    t_job               r_job;

    logic [VERT_W-1:0]  r_vx;
    logic [VERT_W-1:0]  r_vy;
    logic [VERT_W-1:0]  r_vz;
    logic [FACE_W-1:0]  r_face;
    logic [NORM_W-1:0]  r_norm;
    logic [COUNT_W-1:0] r_faces;
    logic               r_last;

    logic               w_adv;
    logic               w_step;
    logic [FACE_W-1:0]  w_face;
    logic [2:0]         w_off;
    logic [NFACE-1:0]   w_rest;

    assign w_adv  = !r_ov || o_vert.ready;
    assign w_step = r_busy && w_adv;
    assign w_face = first_face(r_job.mask);
    assign w_off  = corner_off(w_face, r_vert);
    assign w_rest = r_job.mask & ~(NFACE'(1) << w_face);
    assign o_pop  = !r_busy && !i_q_stat.empty;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy  <= 1'b0;
            r_ov    <= 1'b0;
            r_vert  <= '0;
            r_count <= '0;
        end else begin
            if (o_pop) begin
                if (i_head.clr) begin
                    r_count <= '0;
                end else begin
                    r_busy <= 1'b1;
                    r_vert <= '0;
                end
            end
            if (w_step) begin
                r_ov   <= 1'b1;
                r_vert <= r_vert + 2'd1;
                if (r_vert == 2'd0) begin
                    r_count <= r_count + COUNT_W'(1);
                end
                if ((r_vert == 2'd3) && (w_rest == '0)) begin
                    r_busy <= 1'b0;
                end
            end else if (w_adv) begin
                r_ov <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_job <= i_head;
        end
        if (w_step) begin
            // drop the face once its fourth corner goes out
            if (r_vert == 2'd3) begin
                r_job.mask <= w_rest;
            end
            r_vx    <= VERT_W'({1'b0, r_job.x}) + VERT_W'(w_off[2]);
            r_vy    <= VERT_W'({1'b0, r_job.y}) + VERT_W'(w_off[1]);
            r_vz    <= VERT_W'({1'b0, r_job.z}) + VERT_W'(w_off[0]);
            r_face  <= w_face;
            r_norm  <= face_normal(w_face);
            r_faces <= (r_vert == 2'd0) ? (r_count + COUNT_W'(1)) : r_count;
            r_last  <= (r_vert == 2'd3) && (w_rest == '0);
        end
    end

    assign o_vert.valid        = r_ov;
    assign o_vert.vert_x       = r_vx;
    assign o_vert.vert_y       = r_vy;
    assign o_vert.vert_z       = r_vz;
    assign o_vert.face_dir     = r_face;
    assign o_vert.normal_word  = r_norm;
    assign o_vert.faces_so_far = r_faces;
    assign o_vert.last         = r_last;

    `VFCM_ASSERT_IMP(a_busy_has_face, i_clk, i_rst_n, r_busy, r_job.mask != '0, "busy with no face")
    `VFCM_ASSERT_NXT(a_clear_count, i_clk, i_rst_n, o_pop && i_head.clr, r_count == '0, "count not cleared")

endmodule

`default_nettype wire

// ===== sv/voxel_face_cull_mesher.sv =====
`timescale 1ns / 1ps
`default_nettype none
// Channel  Dir  Handshake          Payload
// i_vox    in   valid/ready        kind, vox_x, vox_y, vox_z, filled
// o_vert   out  valid/ready        vert_x/y/z, face_dir, normal_word, faces_so_far, last
//
// Front: a write item is a row read, then a row write back; a mesh item is five row
// reads of the occupancy RAM, one per cycle, then a queue push if the voxel is solid
// with a visible face. Clear and ignored items read no row; the single read port sets
// this order. Back: one vertex per cycle while o_vert is ready, four per visible face,
// from the output register. After reset the occupancy RAM is swept to zero, one row a
// cycle, all 2^(2*clog2(EDGE)) rows (1024 at EDGE 32); i_vox.ready stays low until done.
// A stalled o_vert holds the back end; the front keeps going until the queue fills.

module voxel_face_cull_mesher import vfcm_pkg::*; #(
    parameter int EDGE = EDGE_DEF
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    vfcm_in_if.sink    i_vox,
    vfcm_out_if.source o_vert
);

    localparam int CW  = $clog2(EDGE);
    localparam int RAW = 2 * CW;

    logic            w_push;
    logic            w_pop;
    t_job            w_job;
    t_job            w_head;
    t_q_stat         w_q_stat;
    logic            w_we;
    logic [RAW-1:0]  w_waddr;
    logic [EDGE-1:0] w_wdata;
    logic [RAW-1:0]  w_raddr;
    logic [EDGE-1:0] w_rdata;

    vfcm_ram #(
        .WIDTH (EDGE),
        .DEPTH (1 << RAW)
    ) u_occ (
        .i_clk   (i_clk),
        .i_we    (w_we),
        .i_waddr (w_waddr),
        .i_wdata (w_wdata),
        .i_raddr (w_raddr),
        .o_rdata (w_rdata)
    );

    vfcm_front #(
        .EDGE (EDGE)
    ) u_front (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_vox    (i_vox),
        .i_q_stat (w_q_stat),
        .o_push   (w_push),
        .o_job    (w_job),
        .o_we     (w_we),
        .o_waddr  (w_waddr),
        .o_wdata  (w_wdata),
        .o_raddr  (w_raddr),
        .i_rdata  (w_rdata)
    );

    vfcm_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_job   (w_job),
        .i_pop   (w_pop),
        .o_head  (w_head),
        .o_stat  (w_q_stat)
    );

    vfcm_back u_back (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_head   (w_head),
        .i_q_stat (w_q_stat),
        .o_pop    (w_pop),
        .o_vert   (o_vert)
    );

endmodule

`default_nettype wire
